### rtl/core/hssm_pkg.sv
// Package: phase codes, result word and line-level decode for the sensor master.
package hssm_pkg;

    localparam int unsigned CMD_W     = 8;
    localparam int unsigned READ_W    = 16;
    localparam int unsigned TICKS_W   = 11;
    localparam int unsigned TCNT_W    = 10;
    localparam int unsigned BCNT_W    = 4;
    localparam int unsigned PHASE_W   = 5;
    localparam logic [TICKS_W-1:0] MAX_TICKS = 11'd1024;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE     = 5'd0,
        PH_ST0      = 5'd1,
        PH_ST1      = 5'd2,
        PH_ST2      = 5'd3,
        PH_ST3      = 5'd4,
        PH_ST4      = 5'd5,
        PH_ST5      = 5'd6,
        PH_CMD_LO   = 5'd7,
        PH_CMD_HI   = 5'd8,
        PH_ACK_HI   = 5'd9,
        PH_ACK_LO   = 5'd10,
        PH_WAIT     = 5'd11,
        PH_RD_HI    = 5'd12,
        PH_RD_LO    = 5'd13,
        PH_MACK_LO  = 5'd14,
        PH_MACK_HI  = 5'd15,
        PH_MACK_REL = 5'd16,
        PH_NACK_HI  = 5'd17,
        PH_NACK_LO  = 5'd18
    } t_phase;

    // one result word
    typedef struct packed {
        logic              clock_level;
        logic              data_pull_low;
        logic              busy;
        logic              done;
        logic              ack_error;
        logic [READ_W-1:0] reading;
    } t_result;

    // clock line level held in each phase
    function automatic logic clk_of(input t_phase p);
        logic c;
        case (p)
            PH_ST0, PH_ST1, PH_ST3, PH_ST4, PH_CMD_HI, PH_ACK_HI,
            PH_RD_HI, PH_MACK_HI, PH_NACK_HI: c = 1'b1;
            default: c = 1'b0;
        endcase
        return c;
    endfunction

    // data pull-down per phase; command phases are handled by the caller
    function automatic logic pull_of(input t_phase p);
        logic d;
        case (p)
            PH_ST1, PH_ST2, PH_ST3, PH_MACK_LO, PH_MACK_HI: d = 1'b1;
            default: d = 1'b0;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/humidity_sensor_serial_master_top.sv
// Top level: two-wire humidity sensor master with input and result registers.
// Data path: a word is captured in the input register, then stepped through the
//   sequencer into the result register once the result slot is free or draining.
// Throughput: one word per cycle while the result slot is free or taken; the result
//   register frees the input side whenever the result is taken in the same cycle.
// Reset: synchronous active-low; both stages empty, sequencer idle, phase_ticks = 1.
module humidity_sensor_serial_master_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [hssm_pkg::CMD_W-1:0]       i_command,
    input  logic                             i_data_line,
    // result words
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_clock_level,
    output logic                             o_data_pull_low,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic                             o_ack_error,
    output logic [hssm_pkg::READ_W-1:0]      o_reading,
    // phase_ticks write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hssm_pkg::TICKS_W-1:0]     i_cfg_phase_ticks
);
    import hssm_pkg::*;

    // input register
    logic                r_in_valid;
    logic                r_kind;
    logic [CMD_W-1:0]    r_command;
    logic                r_data_line;

    // result register
    logic                r_out_valid;
    t_result             r_res;

    logic [TICKS_W-1:0]  r_phase_ticks;
    logic                advance;
    t_result             seq_res;

    // step the sequencer when a word is held and the result slot is free or draining
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;
    assign o_cfg_ready = 1'b1;

    hssm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_kind        (r_kind),
        .i_command     (r_command),
        .i_data_line   (r_data_line),
        .i_phase_ticks (r_phase_ticks),
        .o_result      (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase_ticks <= TICKS_W'(1);
        end else begin
            if (i_cfg_valid) begin
                r_phase_ticks <= i_cfg_phase_ticks;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind      <= i_kind;
            r_command   <= i_command;
            r_data_line <= i_data_line;
        end
        if (advance) begin
            r_res <= seq_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_clock_level   = r_res.clock_level;
    assign o_data_pull_low = r_res.data_pull_low;
    assign o_busy_res      = r_res.busy;
    assign o_done_res      = r_res.done;
    assign o_ack_error     = r_res.ack_error;
    assign o_reading       = r_res.reading;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.done) |-> !r_res.busy)
        else $error("done reported while still busy");

    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.ack_error) |-> (r_res.done && r_res.reading == '0))
        else $error("ack error outside done or with data");

    a_read_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.reading != '0) |-> r_res.done)
        else $error("reading shown outside done");

endmodule

### rtl/core/hssm_seq.sv
// Line sequencer: transaction state and the next-state / result logic for one word.
module hssm_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_kind,
    input  logic [hssm_pkg::CMD_W-1:0]       i_command,
    input  logic                             i_data_line,
    input  logic [hssm_pkg::TICKS_W-1:0]     i_phase_ticks,
    output hssm_pkg::t_result                o_result
);
    import hssm_pkg::*;

    t_phase              r_phase,    n_phase;
    logic [BCNT_W-1:0]   r_bit_cnt,  n_bit_cnt;
    logic [TCNT_W-1:0]   r_tick_cnt, n_tick_cnt;
    logic [CMD_W-1:0]    r_cmd,      n_cmd;
    logic [READ_W-1:0]   r_data,     n_data;
    logic                r_err,      n_err;

    logic [TICKS_W-1:0]  len;
    logic [TICKS_W-1:0]  tick_inc;
    logic                finish;
    logic [2:0]          bit_sel;

    // phase length clamped to 1..1024
    always_comb begin
        if (i_phase_ticks == '0) begin
            len = TICKS_W'(1);
        end else if (i_phase_ticks > MAX_TICKS) begin
            len = MAX_TICKS;
        end else begin
            len = i_phase_ticks;
        end
        tick_inc = {1'b0, r_tick_cnt} + TICKS_W'(1);
    end

    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_tick_cnt = r_tick_cnt;
        n_cmd      = r_cmd;
        n_data     = r_data;
        n_err      = r_err;
        finish     = 1'b0;

        if (i_kind) begin
            if (r_phase == PH_IDLE) begin
                n_cmd      = i_command;
                n_bit_cnt  = '0;
                n_tick_cnt = '0;
                n_data     = '0;
                n_err      = 1'b0;
                n_phase    = PH_ST0;
            end
        end else if (r_phase == PH_WAIT) begin
            if (!i_data_line) begin
                n_phase    = PH_RD_HI;
                n_tick_cnt = '0;
                n_bit_cnt  = '0;
            end
        end else if (r_phase != PH_IDLE) begin
            if (tick_inc < len) begin
                n_tick_cnt = tick_inc[TCNT_W-1:0];
            end else begin
                n_tick_cnt = '0;
                case (r_phase)
                    PH_ST0:    n_phase = PH_ST1;
                    PH_ST1:    n_phase = PH_ST2;
                    PH_ST2:    n_phase = PH_ST3;
                    PH_ST3:    n_phase = PH_ST4;
                    PH_ST4:    n_phase = PH_ST5;
                    PH_ST5:    n_phase = PH_CMD_LO;
                    PH_CMD_LO: n_phase = PH_CMD_HI;
                    PH_CMD_HI: begin
                        if (r_bit_cnt >= BCNT_W'(7)) begin
                            n_bit_cnt = '0;
                            n_phase   = PH_ACK_HI;
                        end else begin
                            n_bit_cnt = r_bit_cnt + BCNT_W'(1);
                            n_phase   = PH_CMD_LO;
                        end
                    end
                    PH_ACK_HI: begin
                        if (i_data_line) n_err = 1'b1;
                        n_phase = PH_ACK_LO;
                    end
                    PH_ACK_LO: begin
                        if (!i_data_line) n_err = 1'b1;
                        if (n_err) finish = 1'b1;
                        else n_phase = PH_WAIT;
                    end
                    PH_RD_HI: begin
                        n_data  = {r_data[READ_W-2:0], i_data_line};
                        n_phase = PH_RD_LO;
                    end
                    PH_RD_LO: begin
                        if (r_bit_cnt == BCNT_W'(7)) begin
                            n_phase = PH_MACK_LO;
                        end else if (r_bit_cnt >= BCNT_W'(15)) begin
                            n_phase = PH_NACK_HI;
                        end else begin
                            n_bit_cnt = r_bit_cnt + BCNT_W'(1);
                            n_phase   = PH_RD_HI;
                        end
                    end
                    PH_MACK_LO:  n_phase = PH_MACK_HI;
                    PH_MACK_HI:  n_phase = PH_MACK_REL;
                    PH_MACK_REL: begin
                        n_bit_cnt = BCNT_W'(8);
                        n_phase   = PH_RD_HI;
                    end
                    PH_NACK_HI: n_phase = PH_NACK_LO;
                    PH_NACK_LO: finish  = 1'b1;
                    default:    n_phase = PH_IDLE;
                endcase
            end
        end

        if (finish) begin
            n_phase    = PH_IDLE;
            n_tick_cnt = '0;
            n_bit_cnt  = '0;
        end
    end

    // result shows the lines after the update
    always_comb begin
        bit_sel                = 3'd7 - n_bit_cnt[2:0];
        o_result.clock_level   = clk_of(n_phase);
        o_result.data_pull_low = pull_of(n_phase);
        if (n_phase == PH_CMD_LO || n_phase == PH_CMD_HI) begin
            o_result.data_pull_low = ~n_cmd[bit_sel];
        end
        o_result.busy      = (n_phase != PH_IDLE);
        o_result.done      = finish;
        o_result.ack_error = finish & n_err;
        o_result.reading   = (finish && !n_err) ? n_data : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= '0;
            r_tick_cnt <= '0;
            r_cmd      <= '0;
            r_data     <= '0;
            r_err      <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_tick_cnt <= n_tick_cnt;
            r_cmd      <= n_cmd;
            r_data     <= n_data;
            r_err      <= n_err;
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick_cnt == '0 && r_bit_cnt == '0))
        else $error("idle with live counters");

    a_wait_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_bit_cnt == '0 && !r_err))
        else $error("wait entered with stale bit count or error");

    a_cmd_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CMD_LO || r_phase == PH_CMD_HI) |-> (r_bit_cnt < BCNT_W'(8)))
        else $error("command bit index out of range");

endmodule
